### hdl/address_range_map_splitter_macros.svh
// assertion macros for the address range map splitter
// used by address_range_map_splitter.sv for its concurrent checks; needs clk and rst in scope
`ifndef ADDRESS_RANGE_MAP_SPLITTER_MACROS_SVH
`define ADDRESS_RANGE_MAP_SPLITTER_MACROS_SVH

// condition that must hold at every edge out of reset
`define ARM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked at every edge out of reset
`define ARM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/arm_pkg.sv
// shared types and codes of the address range map splitter
// no dependencies
package arm_pkg;

  // request kinds
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_WRITE  = 3'd3;
  localparam logic [2:0] REQ_LOCK   = 3'd4;
  localparam logic [2:0] REQ_LOCK64 = 3'd5;

  // status codes of the final item
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_ERR = 2'd1;
  localparam logic [1:0] ST_TYPE_ERR = 2'd2;
  localparam logic [1:0] ST_REJECT   = 2'd3;

  // segments per read or write before the walk gives up
  localparam logic [4:0] MAX_SEGS = 5'd16;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [47:0] start;
    logic [48:0] stop;
    logic [3:0]  owner;
    logic [3:0]  handlers;
  } entry_t;

  // results of the shared compare unit
  typedef struct packed {
    logic        start_gt;
    logic        stop_le;
    logic [15:0] part;
  } cmp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CHK,
    S_SHF_RD,
    S_SHF_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_CHK,
    S_WALK_RD,
    S_WALK_CHK,
    S_FINAL
  } state_t;

endpackage

### hdl/address_range_map_splitter.sv
// Sorted address range table with request splitting, one entry per step.
// Each result waits for the output; one request at a time, as s_tready is
// high only in idle, through one ram and one compare unit.
// Reset: synchronous, clears the range count, sequencer and output valid; the
// table contents are left as they are and are only read below the count.
module address_range_map_splitter #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type[2:0], addr[50:3], range_end[99:51], length[115:100],
  // owner[119:116], handler_mask[123:120], zero fill
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // region[3:0], region_owner[7:4], seg_addr[55:8], seg_length[71:56],
  // status[73:72], zero fill
  output logic [79:0]  m_tdata,
  // is_segment
  output logic         m_tuser,
  // last
  output logic         m_tlast
);
  import arm_pkg::*;
  `include "address_range_map_splitter_macros.svh"

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  state_t        state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] wcnt, wcnt_next;
  logic [CW-1:0] range_count, range_count_next;
  logic [48:0]   cur, cur_next;
  logic [15:0]   rem_len, rem_len_next;
  logic [4:0]    nseg, nseg_next;
  logic [1:0]    st, st_next;
  logic [2:0]    rtype;
  logic [48:0]   ins_end;
  logic [3:0]    own, hm;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data, rd_data;
  logic [EW-1:0] rd_raw;
  cmp_t          cmp;
  logic [1:0]    hbit;
  logic          ofree, emit, emit_seg;
  logic [15:0]   emit_len;
  logic [1:0]    emit_st;

  // table storage
  arm_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx[IW-1:0]),
    .rd_data (rd_raw)
  );
  assign rd_data = entry_t'(rd_raw);

  // entry compare against the walk address
  arm_unit u_unit (
    .start (rd_data.start),
    .stop  (rd_data.stop),
    .cur   (cur),
    .len   (rem_len),
    .res   (cmp)
  );

  assign hbit     = rtype[1:0] + 2'd2;
  assign ofree    = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // request latch
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rtype   <= s_tdata[2:0];
      ins_end <= s_tdata[99:51];
      own     <= s_tdata[119:116];
      hm      <= s_tdata[123:120];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      range_count <= '0;
    end else begin
      state       <= state_next;
      range_count <= range_count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    ptr     <= ptr_next;
    wcnt    <= wcnt_next;
    cur     <= cur_next;
    rem_len <= rem_len_next;
    nseg    <= nseg_next;
    st      <= st_next;
  end

  // sequencer
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    ptr_next         = ptr;
    wcnt_next        = wcnt;
    range_count_next = range_count;
    cur_next         = cur;
    rem_len_next     = rem_len;
    nseg_next        = nseg;
    st_next          = st;
    wr_en            = 1'b0;
    wr_addr          = idx[IW-1:0];
    wr_data          = rd_data;
    emit             = 1'b0;
    emit_seg         = 1'b0;
    emit_len         = 16'd0;
    emit_st          = st;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cur_next     = {1'b0, s_tdata[50:3]};
          rem_len_next = (s_tdata[2:0] == REQ_READ || s_tdata[2:0] == REQ_WRITE) ?
                         s_tdata[115:100] : 16'd0;
          idx_next     = '0;
          wcnt_next    = '0;
          nseg_next    = '0;
          st_next      = ST_ADDR_ERR;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority case (rtype)
          REQ_INSERT: begin
            if ((cur[1:0] != 2'd0) || (ins_end[1:0] != 2'd0) || (cur >= ins_end) ||
                (ins_end[48] && ins_end[47:0] != 48'd0) ||
                (range_count == CW'(TABLE_DEPTH))) begin
              st_next    = ST_REJECT;
              state_next = S_FINAL;
            end else begin
              state_next = S_INS_RD;
            end
          end
          REQ_REMOVE: state_next = S_REM_RD;
          REQ_READ, REQ_WRITE, REQ_LOCK, REQ_LOCK64: state_next = S_WALK_RD;
          default: state_next = S_IDLE;
        endcase
      end
      // find the insert point
      S_INS_RD: begin
        if (idx >= range_count) begin
          ptr_next = idx;
          if (range_count != idx) begin
            idx_next   = range_count - CW'(1);
            state_next = S_SHF_RD;
          end else begin
            state_next = S_INS_PUT;
          end
        end else begin
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (cmp.stop_le) begin
          idx_next   = idx + CW'(1);
          state_next = S_INS_RD;
        end else if ({1'b0, rd_data.start} < ins_end) begin
          st_next    = ST_REJECT;
          state_next = S_FINAL;
        end else begin
          ptr_next   = idx;
          idx_next   = range_count - CW'(1);
          state_next = S_SHF_RD;
        end
      end
      // move entries up by one from the top down
      S_SHF_RD: state_next = S_SHF_WR;
      S_SHF_WR: begin
        wr_en   = 1'b1;
        wr_addr = IW'(idx + CW'(1));
        if (idx == ptr) begin
          state_next = S_INS_PUT;
        end else begin
          idx_next   = idx - CW'(1);
          state_next = S_SHF_RD;
        end
      end
      S_INS_PUT: begin
        wr_en            = 1'b1;
        wr_addr          = ptr[IW-1:0];
        wr_data.start    = cur[47:0];
        wr_data.stop     = ins_end;
        wr_data.owner    = own;
        wr_data.handlers = hm;
        range_count_next = range_count + CW'(1);
        st_next          = ST_OK;
        state_next       = S_FINAL;
      end
      // compact the table without the owner
      S_REM_RD: begin
        if (idx >= range_count) begin
          range_count_next = wcnt;
          st_next          = ST_OK;
          state_next       = S_FINAL;
        end else begin
          state_next = S_REM_CHK;
        end
      end
      S_REM_CHK: begin
        if (rd_data.owner != own) begin
          wr_en     = 1'b1;
          wr_addr   = wcnt[IW-1:0];
          wcnt_next = wcnt + CW'(1);
        end
        idx_next   = idx + CW'(1);
        state_next = S_REM_RD;
      end
      // split walk over consecutive ranges
      S_WALK_RD: begin
        state_next = (idx >= range_count) ? S_FINAL : S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (cmp.start_gt) begin
          state_next = S_FINAL;
        end else if (cmp.stop_le) begin
          idx_next   = idx + CW'(1);
          state_next = S_WALK_RD;
        end else if (!rd_data.handlers[hbit]) begin
          st_next    = ST_TYPE_ERR;
          state_next = S_FINAL;
        end else if (rtype == REQ_LOCK || rtype == REQ_LOCK64) begin
          if (ofree) begin
            emit       = 1'b1;
            emit_seg   = 1'b1;
            st_next    = ST_OK;
            state_next = S_FINAL;
          end
        end else if (nseg == MAX_SEGS) begin
          st_next    = ST_ADDR_ERR;
          state_next = S_FINAL;
        end else if (ofree) begin
          emit         = 1'b1;
          emit_seg     = 1'b1;
          emit_len     = cmp.part;
          nseg_next    = nseg + 5'd1;
          st_next      = ST_OK;
          rem_len_next = rem_len - cmp.part;
          cur_next     = cur + {33'd0, cmp.part};
          if (rem_len == cmp.part) begin
            state_next = S_FINAL;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_WALK_RD;
          end
        end
      end
      S_FINAL: begin
        emit_st = (st == ST_OK && rem_len != 16'd0) ? ST_ADDR_ERR : st;
        if (ofree) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= emit_seg;
      m_tlast <= !emit_seg;
      if (emit_seg) begin
        m_tdata <= {6'd0, ST_OK, emit_len, cur[47:0], rd_data.owner, 4'(idx)};
      end else begin
        m_tdata <= {6'd0, emit_st, 72'd0};
      end
    end
  end

  `ARM_ASSERT_ALWAYS(a_count_bound, range_count <= CW'(TABLE_DEPTH), "range count past depth")
  `ARM_ASSERT_IMPL(a_seg_not_last, m_tvalid && m_tuser, !m_tlast && m_tdata[73:72] == ST_OK, "bad segment item")
  `ARM_ASSERT_IMPL(a_count_step, range_count > $past(range_count), range_count == $past(range_count) + CW'(1), "count jumped")
  `ARM_ASSERT_IMPL(a_busy_no_ready, state != S_IDLE, !s_tready, "ready while busy")

endmodule

### hdl/arm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module arm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/arm_unit.sv
// shared compare and subtract unit: checks one entry against the walk address
// depends on arm_pkg
module arm_unit (
  input  logic [47:0]        start,
  input  logic [48:0]        stop,
  input  logic [48:0]        cur,
  input  logic [15:0]        len,
  output arm_pkg::cmp_t      res
);
  import arm_pkg::*;

  logic [49:0] diff;

  // distance from address to range end, clipped to the bytes left
  always_comb begin
    diff         = {1'b0, stop} - {1'b0, cur};
    res.stop_le  = diff[49] || (diff == 50'd0);
    res.start_gt = ({1'b0, start} > cur);
    if (diff[49:16] != 34'd0 || diff[15:0] >= len) begin
      res.part = len;
    end else begin
      res.part = diff[15:0];
    end
  end

endmodule
